[hdl/dot_bracket_pair_matcher_unit_macros.svh]
// Assertion macros for the bracket pair matcher.
// Define NO_ASSERTIONS to compile the assertions away.
`ifndef DOT_BRACKET_PAIR_MATCHER_UNIT_MACROS_SVH
`define DOT_BRACKET_PAIR_MATCHER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define DBPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DBPM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define DBPM_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define DBPM_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[hdl/dbpm_pkg.sv]
`default_nettype none

package dbpm_pkg;

   localparam int MAX_LEN   = 1024;
   localparam int NUM_TYPES = 30;

   localparam int SYM_W    = 8;
   localparam int POS_W    = 11;
   localparam int STATUS_W = 2;

   // depth / position counters hold 0..MAX_LEN
   localparam int CNT_W     = $clog2(MAX_LEN + 1);
   localparam int IDX_W     = $clog2(MAX_LEN);
   localparam int TYPE_W    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int RAM_DEPTH = NUM_TYPES * MAX_LEN;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam int OPEN_W    = $clog2(RAM_DEPTH + 1);

   localparam logic [STATUS_W-1:0] ST_PAIR = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DOT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OPEN = 2'd3;

   localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [SYM_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [SYM_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [SYM_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [SYM_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [SYM_W-1:0] CH_LANGLE = 8'h3C;
   localparam logic [SYM_W-1:0] CH_RANGLE = 8'h3E;
   localparam logic [SYM_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [SYM_W-1:0] CH_UP_A   = 8'h41;
   localparam logic [SYM_W-1:0] CH_UP_Z   = 8'h5A;
   localparam logic [SYM_W-1:0] CH_LO_A   = 8'h61;
   localparam logic [SYM_W-1:0] CH_LO_Z   = 8'h7A;

   localparam int LETTER_BASE = 4;

   typedef struct packed {
      logic              hit;
      logic [TYPE_W-1:0] idx;
   } dbpm_bracket_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_PAIR,
      KIND_DOT,
      KIND_ERR
   } dbpm_kind_type;

   function automatic dbpm_bracket_type opener_decode(input logic [SYM_W-1:0] sym);
      int               t;
      dbpm_bracket_type r;
      case (sym) inside
         CH_LPAREN:          t = 0;
         CH_LBRACE:          t = 1;
         CH_LBRACK:          t = 2;
         CH_LANGLE:          t = 3;
         [CH_UP_A:CH_UP_Z]:  t = LETTER_BASE + int'(sym - CH_UP_A);
         default:            t = -1;
      endcase
      r.hit = (t >= 0) && (t < NUM_TYPES);
      r.idx = TYPE_W'(t);
      return r;
   endfunction

   function automatic dbpm_bracket_type closer_decode(input logic [SYM_W-1:0] sym);
      int               t;
      dbpm_bracket_type r;
      case (sym) inside
         CH_RPAREN:          t = 0;
         CH_RBRACE:          t = 1;
         CH_RBRACK:          t = 2;
         CH_RANGLE:          t = 3;
         [CH_LO_A:CH_LO_Z]:  t = LETTER_BASE + int'(sym - CH_LO_A);
         default:            t = -1;
      endcase
      r.hit = (t >= 0) && (t < NUM_TYPES);
      r.idx = TYPE_W'(t);
      return r;
   endfunction

   // stack t occupies a contiguous MAX_LEN-entry region of the RAM
   function automatic logic [ADDR_W-1:0] ram_addr(input logic [TYPE_W-1:0] t,
                                                  input logic [IDX_W-1:0]  i);
      return ADDR_W'(t) * ADDR_W'(MAX_LEN) + ADDR_W'(i);
   endfunction

endpackage

`default_nettype wire

[hdl/dbpm_if.sv]
`default_nettype none

interface dbpm_req_if;
   import dbpm_pkg::*;

   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             end_of_string;

   modport source (output valid, output symbol, output end_of_string, input ready);
   modport sink   (input valid, input symbol, input end_of_string, output ready);
endinterface

interface dbpm_rsp_if;
   import dbpm_pkg::*;

   logic                valid;
   logic                ready;
   logic [POS_W-1:0]    position;
   logic [POS_W-1:0]    partner;
   logic [STATUS_W-1:0] status;
   logic                last_result;

   modport source (output valid, output position, output partner, output status,
                   output last_result, input ready);
   modport sink   (input valid, input position, input partner, input status,
                   input last_result, output ready);
endinterface

`default_nettype wire

[hdl/dbpm_ram.sv]
`default_nettype none

module dbpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

[hdl/dot_bracket_pair_matcher_unit.sv]
`default_nettype none

// Dot-bracket pair matcher. Takes one structure character per transfer on
// req_if, numbering the characters of a string from 1, and reports on rsp_if:
// a closed bracket pair as two results (opener,closer) then (closer,opener),
// a '.' as one unpaired result, a closer with no opener as one error result
// (status 2, then silence until the end of the string), and, after the final
// character, one status 3 result if openers remain unclosed. last_result marks
// the final result of each character. A new character is taken every cycle
// while each one causes at most one result and rsp_if is not stalled; a closing
// bracket gives two results, three if it also ends a string with openers left,
// on the single result port, and the next character is taken as the last of
// them is handed over. The thirty bracket stacks live in one single-port-write,
// registered-read RAM of NUM_TYPES * MAX_LEN entries, touched at most once per
// character: a push writes the stack top, a pop reads it for the result stage
// through the RAM output register. Stack depths are flip-flops cleared at a
// string end; the RAM needs no clearing pass and is ready right after reset.
module dot_bracket_pair_matcher_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   dbpm_req_if.sink    req_if,
   dbpm_rsp_if.source  rsp_if
);
   import dbpm_pkg::*;

   `include "dot_bracket_pair_matcher_unit_macros.svh"

   // -------------------------------------------------------------------------
   // String state
   // -------------------------------------------------------------------------
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic              err_ff, err_in;
   logic [OPEN_W-1:0] open_cnt_ff, open_cnt_in;   // total entries over all stacks
   logic [CNT_W-1:0]  depth_ff [NUM_TYPES];
   logic [CNT_W-1:0]  depth_in [NUM_TYPES];

   // Result stage: one record per character that reports anything
   logic              s1_valid_ff, s1_valid_in;
   dbpm_kind_type     s1_kind_ff, s1_kind_in;
   logic              s1_extra_ff, s1_extra_in;   // trailing status 3 result
   logic [POS_W-1:0]  s1_pos_ff, s1_pos_in;
   logic [1:0]        s1_step_ff, s1_step_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_position_ff;
   logic [POS_W-1:0]    rsp_partner_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_result_ff;

   // Stack RAM
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [CNT_W-1:0]  ram_wdata, ram_rdata;

   logic              req_accept;
   logic              out_load;
   logic              s1_done;
   logic [CNT_W-1:0]  pos_next;
   dbpm_bracket_type  op_dec, cl_dec;
   logic [TYPE_W-1:0] tidx;
   logic [CNT_W-1:0]  tdepth, tdepth_m1;
   dbpm_kind_type     new_kind;
   logic              new_extra;

   logic [1:0]          n_main, n_total;
   logic                cur_open, cur_last;
   logic [POS_W-1:0]    cur_position, cur_partner;
   logic [STATUS_W-1:0] cur_status;

   dbpm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (RAM_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // -------------------------------------------------------------------------
   // Handshakes
   // -------------------------------------------------------------------------
   assign req_accept   = req_if.valid && req_if.ready;
   assign out_load     = !rsp_valid_ff || rsp_if.ready;
   assign s1_done      = s1_valid_ff && cur_last && out_load;
   // Take a character when the result stage is empty or hands over its
   // final result this cycle. The pop data in the RAM output register stays
   // put until the next accepted character, which is what the stage needs.
   assign req_if.ready = !s1_valid_ff || s1_done;

   // -------------------------------------------------------------------------
   // Character decode and stack update (accept cycle)
   // -------------------------------------------------------------------------
   assign pos_next  = (pos_ff != CNT_W'(MAX_LEN)) ? pos_ff + CNT_W'(1) : pos_ff;
   assign op_dec    = opener_decode(req_if.symbol);
   assign cl_dec    = closer_decode(req_if.symbol);
   assign tidx      = op_dec.hit ? op_dec.idx : cl_dec.idx;
   assign tdepth    = depth_ff[tidx];
   assign tdepth_m1 = tdepth - CNT_W'(1);

   always_comb begin
      pos_in      = pos_ff;
      err_in      = err_ff;
      open_cnt_in = open_cnt_ff;
      depth_in    = depth_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_waddr   = ram_addr(tidx, tdepth[IDX_W-1:0]);
      ram_raddr   = ram_addr(tidx, tdepth_m1[IDX_W-1:0]);
      ram_wdata   = pos_next;
      new_kind    = KIND_NONE;
      new_extra   = 1'b0;

      if (req_accept) begin
         pos_in = pos_next;
         // after an error the rest of the string is ignored
         if (!err_ff) begin
            if (op_dec.hit) begin
               // push; a full stack drops the opener
               if (tdepth != CNT_W'(MAX_LEN)) begin
                  ram_we         = 1'b1;
                  depth_in[tidx] = tdepth + CNT_W'(1);
                  open_cnt_in    = open_cnt_ff + OPEN_W'(1);
               end
            end else if (cl_dec.hit) begin
               if (tdepth == '0) begin
                  new_kind = KIND_ERR;
                  err_in   = 1'b1;
               end else begin
                  // pop; the opener position arrives next cycle
                  ram_re         = 1'b1;
                  depth_in[tidx] = tdepth_m1;
                  open_cnt_in    = open_cnt_ff - OPEN_W'(1);
                  new_kind       = KIND_PAIR;
               end
            end else if (req_if.symbol == CH_DOT) begin
               new_kind = KIND_DOT;
            end
         end

         if (req_if.end_of_string) begin
            new_extra   = !err_in && (open_cnt_in != '0);
            pos_in      = '0;
            err_in      = 1'b0;
            open_cnt_in = '0;
            for (int i = 0; i < NUM_TYPES; i++) begin
               depth_in[i] = '0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result stage: walks through the results of one character
   // -------------------------------------------------------------------------
   assign n_main   = (s1_kind_ff == KIND_PAIR) ? 2'd2 :
                     (s1_kind_ff == KIND_NONE) ? 2'd0 : 2'd1;
   assign n_total  = n_main + {1'b0, s1_extra_ff};
   assign cur_open = (s1_step_ff == n_main);
   assign cur_last = (s1_step_ff + 2'd1 == n_total);

   always_comb begin
      cur_position = '0;
      cur_partner  = '0;
      cur_status   = ST_OPEN;
      if (!cur_open) begin
         case (s1_kind_ff)
            KIND_PAIR: begin
               cur_status = ST_PAIR;
               if (s1_step_ff == 2'd0) begin
                  cur_position = POS_W'(ram_rdata);
                  cur_partner  = s1_pos_ff;
               end else begin
                  cur_position = s1_pos_ff;
                  cur_partner  = POS_W'(ram_rdata);
               end
            end
            KIND_DOT: begin
               cur_status   = ST_DOT;
               cur_position = s1_pos_ff;
            end
            KIND_ERR: begin
               cur_status = ST_ERR;
            end
            default: begin
               cur_status = ST_OPEN;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_extra_in = s1_extra_ff;
      s1_pos_in   = s1_pos_ff;
      s1_step_in  = s1_step_ff;
      if (req_accept && ((new_kind != KIND_NONE) || new_extra)) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = new_kind;
         s1_extra_in = new_extra;
         s1_pos_in   = POS_W'(pos_next);
         s1_step_in  = 2'd0;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end else if (s1_valid_ff && out_load) begin
         s1_step_in = s1_step_ff + 2'd1;
      end
   end

   assign rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         err_ff       <= 1'b0;
         open_cnt_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_TYPES; i++) begin
            depth_ff[i] <= '0;
         end
      end else begin
         pos_ff       <= pos_in;
         err_ff       <= err_in;
         open_cnt_ff  <= open_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff  <= s1_kind_in;
      s1_extra_ff <= s1_extra_in;
      s1_pos_ff   <= s1_pos_in;
      s1_step_ff  <= s1_step_in;
      if (out_load && s1_valid_ff) begin
         rsp_position_ff    <= cur_position;
         rsp_partner_ff     <= cur_partner;
         rsp_status_ff      <= cur_status;
         rsp_last_result_ff <= cur_last;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.position    = rsp_position_ff;
   assign rsp_if.partner     = rsp_partner_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.last_result = rsp_last_result_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   `DBPM_ASSERT_IMP(a_open_is_last, clock, reset,
      rsp_valid_ff && (rsp_status_ff == ST_OPEN), rsp_last_result_ff,
      "unclosed-opener result not marked last")
   `DBPM_ASSERT_IMP(a_err_result_shape, clock, reset,
      rsp_valid_ff && (rsp_status_ff == ST_ERR),
      (rsp_position_ff == '0) && (rsp_partner_ff == '0) && rsp_last_result_ff,
      "error result malformed")
   `DBPM_ASSERT_IMP(a_no_push_in_error, clock, reset,
      err_ff, !ram_we && !ram_re,
      "stack RAM accessed after an error")
   `DBPM_ASSERT_NXT(a_eos_clears, clock, reset,
      req_accept && req_if.end_of_string,
      (pos_ff == '0) && !err_ff && (open_cnt_ff == '0),
      "string state not cleared at end of string")

endmodule

`default_nettype wire

[dv/dot_bracket_pair_matcher_unit_tb.sv]
module dot_bracket_pair_matcher_unit_tb;
   import dbpm_pkg::*;

   // One structure character as offered on the request channel.
   typedef struct {
      logic [SYM_W-1:0] symbol;
      logic             end_of_string;
   } char_item_type;

   // One report as seen on the result channel.
   typedef struct packed {
      logic [POS_W-1:0]    position;
      logic [POS_W-1:0]    partner;
      logic [STATUS_W-1:0] status;
      logic                last_result;
   } report_type;

   logic clock;
   logic reset;

   dbpm_req_if req_if ();
   dbpm_rsp_if rsp_if ();

   dot_bracket_pair_matcher_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Characters still to be offered, and reports still owed by the block.
   char_item_type chars_to_send[$];
   report_type    reports_due[$];
   char_item_type next_char;
   int            miss_count = 0;
   int            cyc = 0;
   int            hold_left = 0;

   // Shadow of the matcher: one stack of opener positions per bracket type,
   // the stack depths, the position counter and the sticky error flag.
   logic [POS_W-1:0] open_stack [NUM_TYPES][MAX_LEN];
   int unsigned      stack_fill [NUM_TYPES];
   int unsigned      char_pos = 0;
   bit               in_error = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cyc <= cyc + 1;

   // Random gaps on both channels, except in a recurring quiet window where
   // both sides run flat out.
   function automatic bit gaps_on();
      return (cyc % 1500) < 1100;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [SYM_W-1:0] open_sym(input int t);
      case (t)
         0:       return CH_LPAREN;
         1:       return CH_LBRACE;
         2:       return CH_LBRACK;
         3:       return CH_LANGLE;
         default: return CH_UP_A + SYM_W'(t - LETTER_BASE);
      endcase
   endfunction

   function automatic logic [SYM_W-1:0] close_sym(input int t);
      case (t)
         0:       return CH_RPAREN;
         1:       return CH_RBRACE;
         2:       return CH_RBRACK;
         3:       return CH_RANGLE;
         default: return CH_LO_A + SYM_W'(t - LETTER_BASE);
      endcase
   endfunction

   function automatic void add_char(input logic [SYM_W-1:0] sym, input logic eos);
      char_item_type c;
      c.symbol        = sym;
      c.end_of_string = eos;
      chars_to_send   = {chars_to_send, c};
   endfunction

   // Random bracket type that still has an opener outstanding.
   function automatic int pick_open(input int open_cnt[NUM_TYPES]);
      int t;
      t = $urandom_range(0, NUM_TYPES - 1);
      while (open_cnt[t] == 0) t = (t + 1) % NUM_TYPES;
      return t;
   endfunction

   // One structure string. Mostly well nested with dots and noise mixed in;
   // some strings leave openers behind, some throw in stray closers.
   task automatic add_random_string();
      int               len;
      int               mode;
      int               r;
      int               t;
      int               total;
      int               open_cnt[NUM_TYPES];
      logic [SYM_W-1:0] s[$];
      len   = $urandom_range(1, 40);
      r     = $urandom_range(0, 99);
      mode  = (r < 75) ? 0 : (r < 85) ? 1 : 2;   // 0 clean, 1 left open, 2 stray closers
      total = 0;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            t = $urandom_range(0, NUM_TYPES - 1);
            s = {s, open_sym(t)};
            open_cnt[t]++;
            total++;
         end else if (r < 65) begin
            if (mode == 2 && $urandom_range(0, 3) == 0) begin
               s = {s, close_sym($urandom_range(0, NUM_TYPES - 1))};
            end else if (total > 0) begin
               t = pick_open(open_cnt);
               s = {s, close_sym(t)};
               open_cnt[t]--;
               total--;
            end else begin
               s = {s, CH_DOT};
            end
         end else if (r < 90) begin
            s = {s, CH_DOT};
         end else begin
            s = {s, SYM_W'($urandom_range(0, 255))};
         end
      end
      if (mode != 1) begin
         while (total > 0) begin
            t = pick_open(open_cnt);
            s = {s, close_sym(t)};
            open_cnt[t]--;
            total--;
         end
      end
      foreach (s[i]) add_char(s[i], i == s.size() - 1);
   endtask

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   // Bracket type of a symbol and whether it closes; -1 for anything else.
   function automatic int bracket_class(input logic [SYM_W-1:0] sym, output bit closing);
      int t;
      t       = -1;
      closing = 1'b0;
      if (sym >= CH_UP_A && sym <= CH_UP_Z) begin
         t = LETTER_BASE + int'(sym - CH_UP_A);
      end else if (sym >= CH_LO_A && sym <= CH_LO_Z) begin
         t       = LETTER_BASE + int'(sym - CH_LO_A);
         closing = 1'b1;
      end else begin
         for (int k = 0; k < LETTER_BASE; k++) begin
            if (sym == open_sym(k)) t = k;
            if (sym == close_sym(k)) begin
               t       = k;
               closing = 1'b1;
            end
         end
      end
      if (t >= NUM_TYPES) t = -1;
      return t;
   endfunction

   function automatic report_type make_report(input int unsigned pos, input int unsigned mate,
                                              input logic [STATUS_W-1:0] st);
      report_type r;
      r.position    = POS_W'(pos);
      r.partner     = POS_W'(mate);
      r.status      = st;
      r.last_result = 1'b0;
      return r;
   endfunction

   // Advance the shadow by one accepted character and queue the reports it owes.
   task automatic match_brackets(input logic [SYM_W-1:0] sym, input logic eos);
      int          t;
      bit          closing;
      bit          any_open;
      int unsigned opener_pos;
      report_type  batch[$];
      if (char_pos < MAX_LEN) char_pos++;    // saturates on overlong strings
      if (!in_error) begin
         t = bracket_class(sym, closing);
         if (t >= 0 && !closing) begin
            // a push onto a full stack is dropped
            if (stack_fill[t] < MAX_LEN) begin
               open_stack[t][stack_fill[t]] = POS_W'(char_pos);
               stack_fill[t]++;
            end
         end else if (t >= 0) begin
            if (stack_fill[t] == 0) begin
               // closer with nothing to close: error, then silence
               batch    = {batch, make_report(0, 0, ST_ERR)};
               in_error = 1'b1;
            end else begin
               stack_fill[t]--;
               opener_pos = open_stack[t][stack_fill[t]];
               batch = {batch, make_report(opener_pos, char_pos, ST_PAIR)};
               batch = {batch, make_report(char_pos, opener_pos, ST_PAIR)};
            end
         end else if (sym == CH_DOT) begin
            batch = {batch, make_report(char_pos, 0, ST_DOT)};
         end
      end
      if (eos) begin
         any_open = 1'b0;
         foreach (stack_fill[k]) if (stack_fill[k] != 0) any_open = 1'b1;
         if (!in_error && any_open) batch = {batch, make_report(0, 0, ST_OPEN)};
         foreach (stack_fill[k]) stack_fill[k] = 0;
         char_pos = 0;
         in_error = 1'b0;
      end
      if (batch.size() != 0) batch[batch.size() - 1].last_result = 1'b1;
      foreach (batch[i]) reports_due = {reports_due, batch[i]};
   endtask

   // ------------------------------------------------------------------
   // Request driver: holds an offered character until its transfer, then
   // either offers the next one or idles.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid         <= 1'b0;
         req_if.symbol        <= '0;
         req_if.end_of_string <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (chars_to_send.size() != 0 && !(gaps_on() && $urandom_range(0, 99) < 32)) begin
            next_char             = chars_to_send.pop_front();
            req_if.valid         <= 1'b1;
            req_if.symbol        <= next_char.symbol;
            req_if.end_of_string <= next_char.end_of_string;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result-side ready: random stalls, plus one long hold-off early in the
   // random part so the block backs up and stops taking characters.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (cyc == 400) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= 250;
      end else begin
         rsp_if.ready <= !(gaps_on() && $urandom_range(0, 99) < 32);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predicts on each request transfer before checking the result
   // transfer of the same edge, so a same-cycle result still finds its entry.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      report_type want;
      report_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            match_brackets(req_if.symbol, req_if.end_of_string);
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{position: rsp_if.position, partner: rsp_if.partner,
                    status: rsp_if.status, last_result: rsp_if.last_result};
            if (reports_due.size() == 0) begin
               $display("%0t: unexpected report pos=%0d partner=%0d status=%0d last=%0b",
                        $time, got.position, got.partner, got.status, got.last_result);
               miss_count++;
            end else begin
               want = reports_due.pop_front();
               if (got !== want) begin
                  $display({"%0t: wrong report, expected pos=%0d partner=%0d status=%0d ",
                            "last=%0b, actual pos=%0d partner=%0d status=%0d last=%0b"},
                           $time, want.position, want.partner, want.status,
                           want.last_result, got.position, got.partner, got.status,
                           got.last_result);
                  miss_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      reset = 1'b1;

      // Directed strings.
      // Pair around a dot, the symbol extremes, then an opener left at the end.
      add_char(CH_LPAREN, 1'b0);
      add_char(CH_DOT, 1'b0);
      add_char(CH_RPAREN, 1'b0);
      add_char(8'h00, 1'b0);
      add_char(8'hFF, 1'b0);
      add_char(CH_LBRACK, 1'b1);
      // Nested brace and angle, string ends on a closing pair.
      add_char(CH_LBRACE, 1'b0);
      add_char(CH_LANGLE, 1'b0);
      add_char(CH_RANGLE, 1'b0);
      add_char(CH_RBRACE, 1'b1);
      // Outermost letter types; the last closer also leaves 'A' open (3 reports).
      add_char(CH_UP_A, 1'b0);
      add_char(CH_LPAREN, 1'b0);
      add_char(CH_UP_Z, 1'b0);
      add_char(CH_LO_Z, 1'b0);
      add_char(CH_RPAREN, 1'b1);
      // Closer on empty stack: error stays sticky, no unclosed report at the end.
      add_char(CH_RPAREN, 1'b0);
      add_char(CH_DOT, 1'b0);
      add_char(CH_LPAREN, 1'b1);
      // Single-character strings: dot, stray closer, other symbol.
      add_char(CH_DOT, 1'b1);
      add_char(CH_RBRACK, 1'b1);
      add_char(8'h80, 1'b1);

      // Random strings.
      begin
         int base;
         base = chars_to_send.size();
         while (chars_to_send.size() - base < 480) add_random_string();
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything offered, transferred and answered.
      while (chars_to_send.size() != 0 || req_if.valid || reports_due.size() != 0)
         @(negedge clock);
      repeat (16) @(posedge clock);

      if (miss_count == 0 && reports_due.size() == 0) begin
         $display("dot_bracket_pair_matcher_unit: match");
      end else begin
         $display("dot_bracket_pair_matcher_unit: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("dot_bracket_pair_matcher_unit: mismatch");
      $finish;
   end

endmodule
